// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/tnsi_pkg.sv
// ----------------------------------------------------------------------------
// tnsi_pkg
// Types, widths and codes shared by the sorted top-N table.
// ----------------------------------------------------------------------------
package tnsi_pkg;

   // Built table depth and field widths
   localparam int DEPTH_DEF  = 64;
   localparam int CNT_W      = 32;
   localparam int ID_W       = 64;
   localparam int LIM_W      = 7;
   localparam int RANK_W     = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 112;

   // Register reset values
   localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd50;
   localparam logic [CNT_W-1:0] MIN_RESET   = 32'd1024;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_LIMIT = 1'b0,
      CSR_MIN_COUNT   = 1'b1
   } csr_idx_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OFFER_CHECK,
      ST_SCAN_READ,
      ST_SCAN_CMP,
      ST_PLACE_TOP,
      ST_FINISH,
      ST_DUMP_CHECK,
      ST_DUMP_READ,
      ST_DUMP_OUT
   } state_type;

   // Entry index operations
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_TOP,
      IDX_ZERO,
      IDX_DEC,
      IDX_INC
   } idx_op_type;

   // Output register load selection
   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_OFFER,
      OUT_ENTRY
   } out_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic        latch;       // capture the request item
      idx_op_type  idx_op;
      logic        wr_en;       // write one table entry
      logic        wr_shift;    // 1: move the read entry, 0: write the new entry
      logic        wr_at_next;  // 1: write at index+1, 0: write at index 0
      logic        res_set;     // record the offer outcome
      logic        res_acc;
      logic        res_at_next; // 1: rank index+1, 0: rank zero
      logic        total_inc;   // grow the fill level unless full
      out_sel_type out_sel;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic             req_func;   // kind of the item on the request port
      logic             below_min;
      logic             lim_zero;
      logic             tbl_empty;
      logic             tbl_full;
      logic             at_top;     // index is on the last stored entry
      logic             idx_zero;
      logic             stored_gt;  // read entry count above the offered count
      logic             out_free;
      logic [LIM_W-1:0] fill_level;
      logic [LIM_W-1:0] eff_limit;
   } sts_type;

endpackage

// File: sv/tnsi_ctrl.sv
// ----------------------------------------------------------------------------
// tnsi_ctrl
// Sequencer for offers (bottom-up scan with shift) and table readout.
// ----------------------------------------------------------------------------
module tnsi_ctrl
   import tnsi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.req_func ? ST_DUMP_CHECK : ST_OFFER_CHECK;
            end
         end
         ST_OFFER_CHECK: begin
            if (sts.below_min || sts.lim_zero || sts.tbl_empty) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN_READ;
            end
         end
         ST_SCAN_READ: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (sts.stored_gt) begin
               state_in = ST_FINISH;
            end else if (sts.idx_zero) begin
               state_in = ST_PLACE_TOP;
            end else begin
               state_in = ST_SCAN_READ;
            end
         end
         ST_PLACE_TOP: state_in = ST_FINISH;
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP_CHECK: begin
            state_in = sts.tbl_empty ? ST_FINISH : ST_DUMP_READ;
         end
         ST_DUMP_READ: state_in = ST_DUMP_OUT;
         ST_DUMP_OUT: begin
            if (sts.out_free) begin
               state_in = sts.at_top ? ST_IDLE : ST_DUMP_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      req_tready      = 1'b0;
      cmd             = '0;
      cmd.idx_op      = IDX_HOLD;
      cmd.out_sel     = OUT_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         ST_OFFER_CHECK: begin
            if (sts.below_min || sts.lim_zero) begin
               cmd.res_set = 1'b1;
            end else if (sts.tbl_empty) begin
               cmd.wr_en     = 1'b1;
               cmd.res_set   = 1'b1;
               cmd.res_acc   = 1'b1;
               cmd.total_inc = 1'b1;
            end else begin
               cmd.idx_op = IDX_TOP;
            end
         end
         ST_SCAN_CMP: begin
            if (sts.stored_gt) begin
               cmd.res_set = 1'b1;
               // a strictly larger last entry of a full table rejects the offer
               if (!(sts.at_top && sts.tbl_full)) begin
                  cmd.wr_en       = 1'b1;
                  cmd.wr_at_next  = 1'b1;
                  cmd.res_acc     = 1'b1;
                  cmd.res_at_next = 1'b1;
                  cmd.total_inc   = 1'b1;
               end
            end else begin
               // shift down; the last entry of a full table drops out
               if (!(sts.at_top && sts.tbl_full)) begin
                  cmd.wr_en      = 1'b1;
                  cmd.wr_shift   = 1'b1;
                  cmd.wr_at_next = 1'b1;
               end
               if (!sts.idx_zero) begin
                  cmd.idx_op = IDX_DEC;
               end
            end
         end
         ST_PLACE_TOP: begin
            cmd.wr_en     = 1'b1;
            cmd.res_set   = 1'b1;
            cmd.res_acc   = 1'b1;
            cmd.total_inc = 1'b1;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_sel = OUT_OFFER;
            end
         end
         ST_DUMP_CHECK: begin
            if (sts.tbl_empty) begin
               cmd.res_set = 1'b1;
            end else begin
               cmd.idx_op = IDX_ZERO;
            end
         end
         ST_DUMP_OUT: begin
            if (sts.out_free) begin
               cmd.out_sel = OUT_ENTRY;
               if (!sts.at_top) begin
                  cmd.idx_op = IDX_INC;
               end
            end
         end
         default: begin
            cmd.idx_op = IDX_HOLD;
         end
      endcase
   end

endmodule

// File: sv/tnsi_dpath.sv
// ----------------------------------------------------------------------------
// tnsi_dpath
// Entry memory, registers, fill level and result register of the table.
// ----------------------------------------------------------------------------
module tnsi_dpath
   import tnsi_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request payload
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // controller link
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam int               AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);

   // Entry memory
   logic [CNT_W-1:0] count_mem [DEPTH];
   logic [ID_W-1:0]  id_mem    [DEPTH];
   logic [CNT_W-1:0] rd_count_ff;
   logic [ID_W-1:0]  rd_id_ff;

   // Latched request and scan state
   logic [CNT_W-1:0] cnt_ff;
   logic [ID_W-1:0]  id_ff;
   logic [AW-1:0]    idx_ff;
   logic [AW-1:0]    idx_in;
   logic             res_acc_ff;
   logic [RANK_W-1:0] res_pos_ff;

   // Configuration and fill level
   logic [LIM_W-1:0] limit_ff;
   logic [CNT_W-1:0] min_ff;
   logic [LIM_W-1:0] total_ff;
   logic [LIM_W-1:0] total_in;
   logic [LIM_W-1:0] eff_limit;
   logic [LIM_W-1:0] new_limit;
   logic [LIM_W-1:0] new_eff;

   // Result register
   logic              out_valid_ff;
   logic              out_acc_ff;
   logic [RANK_W-1:0] out_rank_ff;
   logic [CNT_W-1:0]  out_count_ff;
   logic [ID_W-1:0]   out_id_ff;
   logic              out_ev_ff;
   logic [LIM_W-1:0]  out_fill_ff;
   logic              out_last_ff;

   // Write port
   logic [AW-1:0]    idx_next;
   logic [AW-1:0]    wr_addr;
   logic [CNT_W-1:0] wr_count;
   logic [ID_W-1:0]  wr_id;
   logic             at_top;
   logic             out_free;

   assign eff_limit = (limit_ff > DEPTH_L) ? DEPTH_L : limit_ff;
   assign new_limit = csr_wdata[LIM_W-1:0];
   assign new_eff   = (new_limit > DEPTH_L) ? DEPTH_L : new_limit;
   assign idx_next  = AW'(idx_ff + AW'(1));
   assign at_top    = (LIM_W'(idx_ff) == LIM_W'(total_ff - LIM_W'(1)));
   assign out_free  = !out_valid_ff || rsp_tready;

   // Status to controller
   always_comb begin
      sts.req_func   = req_tuser;
      sts.below_min  = (cnt_ff < min_ff);
      sts.lim_zero   = (eff_limit == '0);
      sts.tbl_empty  = (total_ff == '0);
      sts.tbl_full   = (total_ff == eff_limit);
      sts.at_top     = at_top;
      sts.idx_zero   = (idx_ff == '0);
      sts.stored_gt  = (rd_count_ff > cnt_ff);
      sts.out_free   = out_free;
      sts.fill_level = total_ff;
      sts.eff_limit  = eff_limit;
   end

   // Latch the request item
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cnt_ff  <= req_tdata[CNT_W-1:0];
         id_ff   <= req_tdata[CNT_W +: ID_W];
      end
   end

   // Advance the entry index
   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD: idx_in = idx_ff;
         IDX_TOP:  idx_in = AW'(total_ff - LIM_W'(1));
         IDX_ZERO: idx_in = '0;
         IDX_DEC:  idx_in = AW'(idx_ff - AW'(1));
         IDX_INC:  idx_in = idx_next;
         default:  idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Record the offer outcome
   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_acc_ff <= cmd.res_acc;
         res_pos_ff <= cmd.res_at_next ? RANK_W'(LIM_W'(idx_ff) + LIM_W'(1)) : '0;
      end
   end

   // Write and read the entry memory
   assign wr_addr  = cmd.wr_at_next ? idx_next : '0;
   assign wr_count = cmd.wr_shift ? rd_count_ff : cnt_ff;
   assign wr_id    = cmd.wr_shift ? rd_id_ff : id_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         count_mem[wr_addr] <= wr_count;
         id_mem[wr_addr]    <= wr_id;
      end
      rd_count_ff <= count_mem[idx_ff];
      rd_id_ff    <= id_mem[idx_ff];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         min_ff   <= MIN_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_TABLE_LIMIT: limit_ff <= new_limit;
            CSR_MIN_COUNT:   min_ff   <= csr_wdata[CNT_W-1:0];
            default:         limit_ff <= limit_ff;
         endcase
      end
   end

   // Fill level: grow on insert, truncate on a lowered limit
   always_comb begin
      total_in = total_ff;
      if (csr_we && (csr_idx_type'(csr_addr) == CSR_TABLE_LIMIT)) begin
         if (total_ff > new_eff) begin
            total_in = new_eff;
         end
      end else if (cmd.total_inc && (total_ff != eff_limit)) begin
         total_in = LIM_W'(total_ff + LIM_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // Result register: load when free, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_sel != OUT_NONE) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.out_sel)
         OUT_OFFER: begin
            out_acc_ff   <= res_acc_ff;
            out_rank_ff  <= res_pos_ff;
            out_count_ff <= '0;
            out_id_ff    <= '0;
            out_ev_ff    <= 1'b0;
            out_fill_ff  <= total_ff;
            out_last_ff  <= 1'b1;
         end
         OUT_ENTRY: begin
            out_acc_ff   <= 1'b0;
            out_rank_ff  <= RANK_W'(idx_ff);
            out_count_ff <= rd_count_ff;
            out_id_ff    <= rd_id_ff;
            out_ev_ff    <= 1'b1;
            out_fill_ff  <= total_ff;
            out_last_ff  <= at_top;
         end
         default: begin
            out_acc_ff <= out_acc_ff;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ev_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_fill_ff, out_id_ff, out_count_ff, out_rank_ff, out_acc_ff};

endmodule

// File: sv/top_n_sorted_insert_table_top.sv
// ----------------------------------------------------------------------------
// top_n_sorted_insert_table_top
// Keeps the largest offered entries, sorted by descending count.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req_     in         tuser: func; tdata: page_count, item_id
// rsp_     out        tuser: entry_valid; tlast: last;
//                     tdata: accepted, rank, out_count, out_id, fill_level
// csr_     in         write enable, register index, write data
//
// An offer passes a check step and ends there when filtered or on an empty
// table; otherwise it walks the stored entries from the bottom up to the insert
// point, a read and a compare step per entry, plus a placing step when it lands
// at rank zero; one memory read port and one write port set that walk.
// A readout has a check step, then a read and an output step per stored entry.
// Reset is synchronous; the entry memory needs no clearing pass.
// A stalled result holds the block in its final step until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module top_n_sorted_insert_table_top
   import tnsi_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // page_count, item_id
   input  logic                  req_tuser,  // func
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // accepted, rank, out_count, out_id,
                                             // fill_level, zero pad
   output logic                  rsp_tuser,  // entry_valid
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   tnsi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tnsi_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Checks
   `ASSERT_CLKD(a_fill_in_limit, clock, reset, sts.fill_level <= sts.eff_limit,
                "fill above limit")
   `ASSERT_CLKD(a_no_write_idle, clock, reset, cmd.wr_en |-> !req_tready, "write while idle")
   `ASSERT_CLKD(a_load_when_free, clock, reset,
                (cmd.out_sel != OUT_NONE) |-> (!rsp_tvalid || rsp_tready),
                "result overwritten")
   `ASSERT_ALWAYS(a_read_not_acc, clock, (rsp_tvalid && rsp_tuser) |-> !rsp_tdata[0],
                  "read result flagged accepted")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted top-N insert table. A directed table
// covers empty reads, the count threshold, ties, a full table and limit
// changes. Random phases follow, each under its own limit and threshold.
// Every result is checked against a shadow copy of the table kept here.
// ----------------------------------------------------------------------------
module tb;
   import tnsi_pkg::*;

   localparam int     CLK_HALF    = 5;
   localparam int     HOLD_CYCLES = 400;
   localparam int     DRAIN_WAIT  = 140;
   localparam longint TIMEOUT_NS  = 20_000_000;

   // One result item as the table returns it
   typedef struct {
      logic              accepted;
      logic [RANK_W-1:0] rank;
      logic [CNT_W-1:0]  count;
      logic [ID_W-1:0]   id;
      logic              valid;
      logic [LIM_W-1:0]  fill;
      logic              last;
   } table_rsp_type;

   typedef enum {ROW_OFFER, ROW_READ, ROW_SET_LIMIT, ROW_SET_MIN} row_kind_type;

   // Directed row; arg is the count of an offer or the value of a write
   typedef struct {
      row_kind_type      kind;
      logic [31:0]       arg;
      logic [ID_W-1:0]   id;
      bit                typed;
      logic              t_acc;
      logic [RANK_W-1:0] t_rank;
      logic [LIM_W-1:0]  t_fill;
   } stim_row_type;

   typedef struct {
      logic [31:0] limit;
      logic [31:0] min;
      int          items;
      int          snd_idle;
      int          rcv_pct;
      bit          pressure;
   } phase_type;

   logic clock = 1'b0;
   logic reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // page_count, item_id
   logic                  req_tuser;   // func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // accepted, rank, out_count, out_id,
                                       // fill_level, zero pad
   logic                  rsp_tuser;   // entry_valid
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow table state
   logic [CNT_W-1:0] shadow_cnt [DEPTH_DEF];
   logic [ID_W-1:0]  shadow_id  [DEPTH_DEF];
   int               shadow_fill;
   logic [LIM_W-1:0] shadow_limit;
   logic [CNT_W-1:0] shadow_min;

   table_rsp_type table_rsp_due [$];
   int         errors = 0;
   int         send_idle = 29;
   int         rcv_idle = 84;
   int         hold_requests = 0;
   int         hold_served = 0;
   int         hold_left = 0;

   top_n_sorted_insert_table_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_HALF) clock = ~clock;

   function automatic int shadow_eff_limit();
      return (shadow_limit > DEPTH_DEF) ? DEPTH_DEF : int'(shadow_limit);
   endfunction

   // Apply one accepted item to the shadow table and queue its results
   task automatic predict_table_step(input logic func, input logic [CNT_W-1:0] cnt,
                                     input logic [ID_W-1:0] id);
      int            lim;
      int            n;
      int            pos;
      int            i;
      table_rsp_type r;
      lim = shadow_eff_limit();
      n   = shadow_fill;
      r   = '{1'b0, '0, '0, '0, 1'b0, '0, 1'b1};
      if (func) begin
         if (n == 0) begin
            table_rsp_due.push_back(r);
         end else begin
            for (i = 0; i < n; i++) begin
               r.rank  = i[RANK_W-1:0];
               r.count = shadow_cnt[i];
               r.id    = shadow_id[i];
               r.valid = 1'b1;
               r.fill  = n[LIM_W-1:0];
               r.last  = (i == n - 1);
               table_rsp_due.push_back(r);
            end
         end
      end else begin
         pos = 0;
         while (pos < n && shadow_cnt[pos] > cnt) pos++;
         if (cnt < shadow_min || pos >= lim) begin
            r.fill = n[LIM_W-1:0];
         end else begin
            // shift lower entries down; the last one drops out when full
            for (i = (n < lim) ? n : lim - 1; i > pos; i--) begin
               shadow_cnt[i] = shadow_cnt[i-1];
               shadow_id[i]  = shadow_id[i-1];
            end
            shadow_cnt[pos] = cnt;
            shadow_id[pos]  = id;
            if (n < lim) shadow_fill = n + 1;
            r.accepted = 1'b1;
            r.rank     = pos[RANK_W-1:0];
            r.fill     = shadow_fill[LIM_W-1:0];
         end
         table_rsp_due.push_back(r);
      end
   endtask

   // Offer one item, wait for the handshake, then record what it should cause
   task automatic send_item(input logic func, input logic [CNT_W-1:0] cnt,
                            input logic [ID_W-1:0] id, input bit typed,
                            input table_rsp_type typed_rsp);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {id, cnt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_table_step(func, cnt, id);
      if (typed) begin
         void'(table_rsp_due.pop_back());
         table_rsp_due.push_back(typed_rsp);
      end
   endtask

   // Drop valid and wait until the table has returned every result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (table_rsp_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TABLE_LIMIT: begin
            shadow_limit = val[LIM_W-1:0];
            if (shadow_fill > shadow_eff_limit()) shadow_fill = shadow_eff_limit();
         end
         CSR_MIN_COUNT: begin
            shadow_min = val;
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         if (errors < 50)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         errors++;
      end
   endtask

   // Receiver: random stalls, plus a long hold-off when the driver asks
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_tready  <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   // Compare each taken result with the oldest one due
   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (table_rsp_due.size() == 0) begin
            if (errors < 50)
               $display("%0t: unexpected result, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = table_rsp_due.pop_front();
            check_field("accepted",    want.accepted, rsp_tdata[0]);
            check_field("rank",        want.rank,     rsp_tdata[6:1]);
            check_field("out_count",   want.count,    rsp_tdata[38:7]);
            check_field("out_id",      want.id,       rsp_tdata[102:39]);
            check_field("fill_level",  want.fill,     rsp_tdata[109:103]);
            check_field("entry_valid", want.valid,    rsp_tuser);
            check_field("last",        want.last,     rsp_tlast);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAILURE");
      $finish;
   end

   initial begin
      stim_row_type  rows [$];
      phase_type     phases [$];
      table_rsp_type typed_rsp;
      logic        func;
      logic [31:0] cnt;
      logic [31:0] tie_base;
      int          k;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_TABLE_LIMIT;
      csr_wdata  <= '0;
      shadow_fill  = 0;
      shadow_limit = LIMIT_RESET;
      shadow_min   = MIN_RESET;
      foreach (shadow_cnt[i]) begin
         shadow_cnt[i] = '0;
         shadow_id[i]  = '0;
      end

      // Directed rows: empty read, threshold, extremes, ties, truncation,
      // zero limit, full table of one, limit written above depth
      rows.push_back('{ROW_READ,  32'd0,        64'd0, 1'b1, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_OFFER, 32'd1023,     64'd9, 1'b1, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_OFFER, 32'd1024,     64'd1, 1'b1, 1'b1, 6'd0, 7'd1});
      rows.push_back('{ROW_OFFER, 32'hFFFFFFFF, '1,    1'b1, 1'b1, 6'd0, 7'd2});
      rows.push_back('{ROW_OFFER, 32'd1024,     64'd2, 1'b1, 1'b1, 6'd1, 7'd3});
      rows.push_back('{ROW_OFFER, 32'd0,        64'd0, 1'b1, 1'b0, 6'd0, 7'd3});
      rows.push_back('{ROW_OFFER, 32'h80000000, 64'hAAAA_AAAA_AAAA_AAAA,
                       1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_OFFER, 32'h7FFFFFFF, 64'h5555_5555_5555_5555,
                       1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_READ,  32'd0,        64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_SET_MIN,   32'd0,    64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_SET_LIMIT, 32'd3,    64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_OFFER, 32'd0,        64'd3, 1'b1, 1'b0, 6'd0, 7'd3});
      rows.push_back('{ROW_OFFER, 32'h7FFFFFFF, 64'd4, 1'b1, 1'b1, 6'd2, 7'd3});
      rows.push_back('{ROW_READ,  32'd0,        64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_SET_LIMIT, 32'd0,    64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_OFFER, 32'hFFFFFFFF, 64'd5, 1'b1, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_READ,  32'd0,        64'd0, 1'b1, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_SET_LIMIT, 32'd1,    64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_OFFER, 32'd0,        64'd5, 1'b1, 1'b1, 6'd0, 7'd1});
      rows.push_back('{ROW_OFFER, 32'd0,        64'd6, 1'b1, 1'b1, 6'd0, 7'd1});
      rows.push_back('{ROW_OFFER, 32'd1,        64'd7, 1'b1, 1'b1, 6'd0, 7'd1});
      rows.push_back('{ROW_READ,  32'd0,        64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_SET_MIN,   32'hFFFFFFFF, 64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_OFFER, 32'hFFFFFFFE, 64'd8, 1'b1, 1'b0, 6'd0, 7'd1});
      rows.push_back('{ROW_OFFER, 32'hFFFFFFFF, 64'd8, 1'b1, 1'b1, 6'd0, 7'd1});
      rows.push_back('{ROW_SET_LIMIT, 32'hFFFFFFFF, 64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_SET_MIN,   32'd0,    64'd0, 1'b0, 1'b0, 6'd0, 7'd0});
      rows.push_back('{ROW_READ,  32'd0,        64'd0, 1'b0, 1'b0, 6'd0, 7'd0});

      // Random phases: limit, threshold, items, sender and receiver idling, hold-off
      phases.push_back('{32'd64,  32'd0,          40, 29, 84, 1'b0});
      phases.push_back('{32'd127, 32'd1024,       40, 29, 84, 1'b0});
      phases.push_back('{32'd8,   32'h80000000,   30, 29, 84, 1'b0});
      phases.push_back('{32'd1,   32'd1024,       20, 84, 29, 1'b0});
      phases.push_back('{32'd64,  32'd0,          40, 84, 29, 1'b1});
      phases.push_back('{32'd20,  32'd500,        30, 84, 29, 1'b0});
      phases.push_back('{32'd0,   32'd0,          10,  0,  0, 1'b0});
      phases.push_back('{32'd50,  32'd1024,       40,  0,  0, 1'b0});
      phases.push_back('{32'd64,  32'hFFFFFFFF,   20,  0,  0, 1'b0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (rows[r]) begin
         case (rows[r].kind)
            ROW_SET_LIMIT: begin
               settle();
               write_reg(CSR_TABLE_LIMIT, rows[r].arg);
            end
            ROW_SET_MIN: begin
               settle();
               write_reg(CSR_MIN_COUNT, rows[r].arg);
            end
            default: begin
               typed_rsp = '{rows[r].t_acc, rows[r].t_rank, 32'd0, 64'd0, 1'b0,
                             rows[r].t_fill, 1'b1};
               send_item(rows[r].kind == ROW_READ, rows[r].arg, rows[r].id,
                         rows[r].typed, typed_rsp);
            end
         endcase
      end

      // Random phases
      typed_rsp = '{1'b0, '0, '0, '0, 1'b0, '0, 1'b0};
      foreach (phases[p]) begin
         settle();
         write_reg(CSR_TABLE_LIMIT, phases[p].limit);
         write_reg(CSR_MIN_COUNT, phases[p].min);
         send_idle = phases[p].snd_idle;
         rcv_idle  = phases[p].rcv_pct;
         tie_base  = shadow_min + $urandom_range(64);
         for (k = 0; k < phases[p].items; k++) begin
            // hold the receiver off so the table backs up into the request side
            if (phases[p].pressure && k == 5) hold_requests <= hold_requests + 1;
            func = ($urandom_range(9) == 0);
            case ($urandom_range(9))
               0:       cnt = shadow_min - 1;
               1:       cnt = shadow_min;
               2, 3, 4: cnt = tie_base + $urandom_range(7);
               5:       cnt = 32'hFFFFFFFF;
               default: cnt = $urandom;
            endcase
            send_item(func, cnt, {$urandom, $urandom}, 1'b0, typed_rsp);
         end
      end

      // Drain, then let the block come to rest
      req_tvalid <= 1'b0;
      while (table_rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && table_rsp_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/tnsi_pkg.sv
sv/tnsi_ctrl.sv
sv/tnsi_dpath.sv
sv/top_n_sorted_insert_table_top.sv
dv/tb.sv
